[rtl/htfd_pkg.sv]
// htfd_pkg: shared types, constants and the crc-8 byte step for the
// humidity/temperature frame decoder. No dependencies.
`timescale 1ns / 1ps

package htfd_pkg;

  localparam int unsigned FRAME_BYTES = 7;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned PAYLOAD_W   = 40;
  localparam int unsigned RAW_W       = 20;
  localparam int unsigned HUM_W       = 10;
  localparam int unsigned TEMP_W      = 12;

  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [9:0]        HUM_SCALE   = 10'd1000;
  localparam logic [10:0]       TEMP_SCALE  = 11'd2000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 12'd500;

  localparam logic STATUS_GOOD    = 1'b0;
  localparam logic STATUS_CRC_BAD = 1'b1;

  // completed frame handed to the scaler
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic                 status;
  } frame_t;

  // msb-first crc-8, one byte unrolled over eight bit steps
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/htfd_frame.sv]
// htfd_frame: byte position tracking, running crc and payload capture.
// Hands each completed frame on through a registered stage. Uses htfd_pkg.
`timescale 1ns / 1ps

module htfd_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_frame_byte,
  input  logic                 in_start_of_frame,
  output logic                 frame_valid,
  input  logic                 frame_stall,
  output htfd_pkg::frame_t     frame_item
);

  logic [htfd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [7:0]                     crc_r, crc_nxt;
  logic [htfd_pkg::PAYLOAD_W-1:0] payload_r, payload_nxt;
  logic                           fvalid_r, fvalid_nxt;
  htfd_pkg::frame_t               fitem_r, fitem_nxt;
  logic                           accept;

  assign in_stall = fvalid_r && frame_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    payload_nxt = payload_r;
    fvalid_nxt  = fvalid_r && frame_stall;
    fitem_nxt   = fitem_r;
    if (accept) begin
      priority if (in_start_of_frame) begin
        crc_nxt = htfd_pkg::crc8_step(htfd_pkg::CRC_INIT, in_frame_byte);
        pos_nxt = htfd_pkg::POS_W'(1);
      end else if (pos_r == htfd_pkg::POS_IDLE) begin
        pos_nxt = pos_r;
      end else if (pos_r < htfd_pkg::POS_LAST) begin
        crc_nxt     = htfd_pkg::crc8_step(crc_r, in_frame_byte);
        payload_nxt = {payload_r[htfd_pkg::PAYLOAD_W-9:0], in_frame_byte};
        pos_nxt     = pos_r + htfd_pkg::POS_W'(1);
      end else begin
        fvalid_nxt        = 1'b1;
        fitem_nxt.payload = payload_r;
        fitem_nxt.status  = (crc_r != in_frame_byte) ? htfd_pkg::STATUS_CRC_BAD
                                                      : htfd_pkg::STATUS_GOOD;
        pos_nxt           = htfd_pkg::POS_IDLE;
        crc_nxt           = htfd_pkg::CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= htfd_pkg::POS_IDLE;
      crc_r    <= htfd_pkg::CRC_INIT;
      fvalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      fvalid_r <= fvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
    fitem_r   <= fitem_nxt;
  end

  assign frame_valid = fvalid_r;
  assign frame_item  = fitem_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= htfd_pkg::POS_LAST)
    else $error("byte position out of range");

  a_idle_crc: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == htfd_pkg::POS_IDLE |-> crc_r == htfd_pkg::CRC_INIT)
    else $error("crc not at initial value while idle");

  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fvalid_r && frame_stall |=> fvalid_r && $stable(fitem_r))
    else $error("stalled frame item lost or changed");

endmodule

[rtl/htfd_scale.sv]
// htfd_scale: scales raw humidity and temperature to tenths and holds the
// result register. Uses htfd_pkg.
`timescale 1ns / 1ps

module htfd_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              frame_valid,
  output logic                              frame_stall,
  input  htfd_pkg::frame_t                  frame_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [htfd_pkg::HUM_W-1:0]        out_humidity_tenths,
  output logic signed [htfd_pkg::TEMP_W-1:0] out_temperature_tenths,
  output logic                              out_status
);

  logic [htfd_pkg::RAW_W-1:0]  raw_h, raw_t;
  logic [29:0]                 hum_prod;
  logic [30:0]                 temp_prod;
  logic [htfd_pkg::HUM_W-1:0]  hum_val;
  logic [htfd_pkg::TEMP_W-1:0] temp_val;
  logic                        load;

  logic                        ovalid_r, ovalid_nxt;
  logic [htfd_pkg::HUM_W-1:0]  hum_r, hum_nxt;
  logic [htfd_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic                        status_r, status_nxt;

  assign frame_stall = ovalid_r && out_stall;
  assign load        = frame_valid && !frame_stall;

  assign raw_h     = frame_item.payload[2*htfd_pkg::RAW_W-1:htfd_pkg::RAW_W];
  assign raw_t     = frame_item.payload[htfd_pkg::RAW_W-1:0];
  assign hum_prod  = {10'd0, raw_h} * {20'd0, htfd_pkg::HUM_SCALE};
  assign temp_prod = {11'd0, raw_t} * {20'd0, htfd_pkg::TEMP_SCALE};
  assign hum_val   = hum_prod[29:20];
  assign temp_val  = {1'b0, temp_prod[30:20]} - htfd_pkg::TEMP_OFFSET;

  always_comb begin
    ovalid_nxt = ovalid_r && out_stall;
    hum_nxt    = hum_r;
    temp_nxt   = temp_r;
    status_nxt = status_r;
    if (load) begin
      ovalid_nxt = 1'b1;
      status_nxt = frame_item.status;
      if (frame_item.status == htfd_pkg::STATUS_CRC_BAD) begin
        hum_nxt  = '0;
        temp_nxt = '0;
      end else begin
        hum_nxt  = hum_val;
        temp_nxt = temp_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hum_r    <= hum_nxt;
    temp_r   <= temp_nxt;
    status_r <= status_nxt;
  end

  assign out_valid              = ovalid_r;
  assign out_humidity_tenths    = hum_r;
  assign out_temperature_tenths = $signed(temp_r);
  assign out_status             = status_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && status_r == htfd_pkg::STATUS_CRC_BAD |-> hum_r == '0 && temp_r == '0)
    else $error("crc error item carries non-zero values");

  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && status_r == htfd_pkg::STATUS_GOOD
      |-> hum_r <= 10'd999 && $signed(temp_r) >= -12'sd500 && $signed(temp_r) <= 12'sd1499)
    else $error("scaled value out of range");

  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ovalid_r && status_r == $past(frame_item.status))
    else $error("frame item not transferred to result register");

endmodule

[rtl/humidity_temp_frame_decoder.sv]
// humidity_temp_frame_decoder: one byte item accepted per cycle while
// in_stall is low; the last byte of a frame passes the frame stage and then
// the result register before its result appears. The byte rate rests on the
// unrolled crc step and the combinational scaling multipliers; the block stalls
// only when both the frame stage and the result register hold items not yet taken.
// Synchronous active-low reset returns to idle with the crc at 0xff.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_frame_byte,
  input  logic                               in_start_of_frame,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [htfd_pkg::HUM_W-1:0]         out_humidity_tenths,
  output logic signed [htfd_pkg::TEMP_W-1:0] out_temperature_tenths,
  output logic                               out_status
);

  logic             frame_valid;
  logic             frame_stall;
  htfd_pkg::frame_t frame_item;

  htfd_frame u_frame (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_frame_byte     (in_frame_byte),
    .in_start_of_frame (in_start_of_frame),
    .frame_valid       (frame_valid),
    .frame_stall       (frame_stall),
    .frame_item        (frame_item)
  );

  htfd_scale u_scale (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .frame_valid            (frame_valid),
    .frame_stall            (frame_stall),
    .frame_item             (frame_item),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths),
    .out_status             (out_status)
  );

endmodule

[verif/humidity_temp_frame_decoder_tb.sv]
// humidity_temp_frame_decoder_tb: self-checking bench for the seven-byte measurement frame
// decoder, with queue-fed driver, scoreboarding monitor and crc/scaling predictor.
// Depends on rtl/htfd_pkg.sv and rtl/humidity_temp_frame_decoder.sv.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_tb;

  typedef struct packed {
    logic [7:0] octet;
    logic       sof;
  } octet_item_t;

  typedef struct packed {
    logic [htfd_pkg::HUM_W-1:0]         hum;
    logic signed [htfd_pkg::TEMP_W-1:0] temp;
    logic                               status;
  } reading_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [7:0]                         in_frame_byte = 8'h00;
  logic                               in_start_of_frame = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [htfd_pkg::HUM_W-1:0]         out_humidity_tenths;
  logic signed [htfd_pkg::TEMP_W-1:0] out_temperature_tenths;
  logic                               out_status;

  octet_item_t pending_octets[$];
  reading_t    expected_readings[$];
  int          mismatches = 0;
  int          cyc = 0;
  int          hold_left = 0;

  // predictor state
  logic [htfd_pkg::POS_W-1:0]     frame_pos = htfd_pkg::POS_IDLE;
  logic [7:0]                     crc_acc = htfd_pkg::CRC_INIT;
  logic [htfd_pkg::PAYLOAD_W-1:0] payload_acc = '0;

  humidity_temp_frame_decoder DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_frame_byte          (in_frame_byte),
    .in_start_of_frame      (in_start_of_frame),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths),
    .out_status             (out_status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // bitwise msb-first crc-8 over one octet
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c  = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic bit roll_idle();
    if (cyc >= 300 && cyc < 450) begin
      return 1'b0;
    end
    return $urandom_range(99) < 9;
  endfunction

  task automatic decode_octet(input logic [7:0] b, input logic sof);
    reading_t    r;
    logic [63:0] h_wide;
    logic [63:0] t_wide;
    if (sof) begin
      crc_acc   = crc8_fold(htfd_pkg::CRC_INIT, b);
      frame_pos = htfd_pkg::POS_W'(1);
    end else if (frame_pos == htfd_pkg::POS_IDLE) begin
    end else if (frame_pos < htfd_pkg::POS_LAST) begin
      crc_acc     = crc8_fold(crc_acc, b);
      payload_acc = {payload_acc[htfd_pkg::PAYLOAD_W-9:0], b};
      frame_pos   = frame_pos + htfd_pkg::POS_W'(1);
    end else begin
      r = '0;
      if (crc_acc != b) begin
        r.status = htfd_pkg::STATUS_CRC_BAD;
      end else begin
        h_wide   = (64'(payload_acc[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W])
                    * 64'(htfd_pkg::HUM_SCALE)) >> htfd_pkg::RAW_W;
        t_wide   = (64'(payload_acc[htfd_pkg::RAW_W-1:0])
                    * 64'(htfd_pkg::TEMP_SCALE)) >> htfd_pkg::RAW_W;
        r.hum    = h_wide[htfd_pkg::HUM_W-1:0];
        r.temp   = t_wide[htfd_pkg::TEMP_W-1:0] - htfd_pkg::TEMP_OFFSET;
        r.status = htfd_pkg::STATUS_GOOD;
      end
      expected_readings.push_back(r);
      frame_pos = htfd_pkg::POS_IDLE;
      crc_acc   = htfd_pkg::CRC_INIT;
    end
  endtask

  task automatic push_octet(input logic [7:0] b, input logic sof);
    octet_item_t it;
    it.octet = b;
    it.sof   = sof;
    pending_octets.push_back(it);
  endtask

  task automatic push_frame(input logic [7:0] stat, input logic [htfd_pkg::PAYLOAD_W-1:0] pl,
                            input bit corrupt);
    logic [7:0] c;
    logic [7:0] b;
    c = crc8_fold(htfd_pkg::CRC_INIT, stat);
    push_octet(stat, 1'b1);
    for (int i = 4; i >= 0; i--) begin
      b = pl[i*8 +: 8];
      c = crc8_fold(c, b);
      push_octet(b, 1'b0);
    end
    if (corrupt) begin
      c = c ^ 8'($urandom_range(255, 1));
    end
    push_octet(c, 1'b0);
  endtask

  initial begin : stimulus
    int r;
    int n;
    // stray bytes while idle
    push_octet(8'hFF, 1'b0);
    push_octet(8'h00, 1'b0);
    // raw extremes
    push_frame(8'h00, '0, 1'b0);
    push_frame(8'hFF, '1, 1'b0);
    // start flag mid-frame, then a crc mismatch
    push_octet(8'h1C, 1'b1);
    push_octet(8'hA5, 1'b0);
    push_octet(8'h5A, 1'b0);
    push_frame(8'h18, 40'h12345_6789A, 1'b1);
    while (pending_octets.size() < 620) begin
      r = $urandom_range(99);
      if (r < 70) begin
        push_frame(8'($urandom), {8'($urandom), 32'($urandom)}, 1'b0);
      end else if (r < 80) begin
        push_frame(8'($urandom), {8'($urandom), 32'($urandom)}, 1'b1);
      end else if (r < 92) begin
        n = $urandom_range(5);
        push_octet(8'($urandom), 1'b1);
        for (int i = 0; i < n; i++) begin
          push_octet(8'($urandom), 1'b0);
        end
      end else begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
          push_octet(8'($urandom), 1'b0);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin : drive
    octet_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_octet(in_frame_byte, in_start_of_frame);
      end
      if (!in_valid || !in_stall) begin
        if (pending_octets.size() > 0 && !roll_idle()) begin
          it = pending_octets.pop_front();
          in_valid          <= 1'b1;
          in_frame_byte     <= it.octet;
          in_start_of_frame <= it.sof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (cyc == 150) begin
      hold_left <= 80;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= roll_idle();
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    reading_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        $display("%0t unexpected item: hum %0d temp %0d status %0d", $realtime,
                 out_humidity_tenths, out_temperature_tenths, out_status);
      end else begin
        e = expected_readings.pop_front();
        if (out_humidity_tenths !== e.hum) begin
          mismatches++;
          $display("%0t humidity: expected %0d actual %0d", $realtime, e.hum,
                   out_humidity_tenths);
        end
        if (out_temperature_tenths !== e.temp) begin
          mismatches++;
          $display("%0t temperature: expected %0d actual %0d", $realtime, e.temp,
                   out_temperature_tenths);
        end
        if (out_status !== e.status) begin
          mismatches++;
          $display("%0t status: expected %0d actual %0d", $realtime, e.status,
                   out_status);
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (pending_octets.size() == 0 && !in_valid && expected_readings.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("humidity_temp_frame_decoder regression: pass");
    end else begin
      $display("humidity_temp_frame_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("humidity_temp_frame_decoder regression: fail");
    $finish;
  end

endmodule
